### rtl/core/bmdt_pkg.sv
package bmdt_pkg;

   // Default sizes of the maps and of the metadata area.
   localparam int BLOCK_COUNT_DEF     = 1024;
   localparam int INODE_COUNT_DEF     = 256;
   localparam int BITS_PER_MAP_DEF    = 256;
   localparam int INODES_PER_META_DEF = 16;
   localparam int META_BLOCKS_DEF     = 32;

   // Item field widths.
   localparam int CMD_W    = 3;
   localparam int NUMBER_W = 10;
   localparam int VALUE_W  = 10;
   localparam int STATUS_W = 2;

   // Register port and register widths.
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 11;
   localparam int BLOCKS_REG_W = 11;
   localparam int INODES_REG_W = 9;
   localparam int META_REG_W   = 6;
   localparam int START_REG_W  = 5;

   // Wide enough to hold the largest metadata block count.
   localparam int META_IDX_W = 7;

   // Bitmap bits held in each memory entry.
   localparam int MAP_WORD_W     = 32;
   localparam int MAP_WORD_SHIFT = 5;

   // A flush reports at most this many indices.
   localparam int FLUSH_MAX   = 32;
   localparam int FLUSH_CNT_W = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC_BLK = 3'd0,
      CMD_FREE_BLK  = 3'd1,
      CMD_QUERY_BLK = 3'd2,
      CMD_ALLOC_INO = 3'd3,
      CMD_FREE_INO  = 3'd4,
      CMD_QUERY_INO = 3'd5,
      CMD_MARK_INO  = 3'd6,
      CMD_FLUSH     = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_CLEAN    = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] REG_BLOCKS_IN_USE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INODES_IN_USE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_META_IN_USE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_MAP_START   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INODE_MAP_START   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_INODE_TABLE_START = 3'd5;

   localparam logic [BLOCKS_REG_W-1:0] BLOCKS_IN_USE_RST     = 11'd1024;
   localparam logic [INODES_REG_W-1:0] INODES_IN_USE_RST     = 9'd256;
   localparam logic [META_REG_W-1:0]   META_IN_USE_RST       = 6'd32;
   localparam logic [START_REG_W-1:0]  BLOCK_MAP_START_RST   = 5'd1;
   localparam logic [START_REG_W-1:0]  INODE_MAP_START_RST   = 5'd2;
   localparam logic [START_REG_W-1:0]  INODE_TABLE_START_RST = 5'd3;

endpackage

### rtl/core/bmdt_if.sv
interface bmdt_req_if;
   import bmdt_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [NUMBER_W-1:0] number;

   modport source (output valid, output cmd, output number, input ready);
   modport sink   (input valid, input cmd, input number, output ready);
endinterface

interface bmdt_rsp_if;
   import bmdt_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic                is_free;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, output value, output is_free, output status, output last,
                   input ready);
   modport sink   (input valid, input value, input is_free, input status, input last,
                   output ready);
endinterface

### rtl/core/bmdt_ram.sv
module bmdt_ram #(
   parameter int WIDTH = bmdt_pkg::MAP_WORD_W,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/bmdt_div.sv
module bmdt_div #(
   parameter int DW = 11,
   parameter int D0 = 256,
   parameter int D1 = 16,
   localparam int MW = DW + 2,
   localparam int PW = DW + MW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          sel,
   input  logic [DW-1:0] dividend,
   output logic          done,
   output logic [DW-1:0] quotient
);

   // The quotient by a fixed divisor d comes from one multiplication by the
   // reciprocal 2^S / d rounded up, with S the dividend width plus the ceiling
   // of log2 of d. The rounding error stays below one step of the quotient
   // over the whole dividend range, so the result is exact.
   localparam int     S0 = DW + $clog2(D0);
   localparam int     S1 = DW + $clog2(D1);
   localparam longint R0 = ((longint'(1) << S0) + longint'(D0) - 1) / longint'(D0);
   localparam longint R1 = ((longint'(1) << S1) + longint'(D1) - 1) / longint'(D1);
   localparam logic [MW-1:0] RECIP0 = MW'(R0);
   localparam logic [MW-1:0] RECIP1 = MW'(R1);

   logic          done_ff, done_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [PW-1:0] prod;

   always_comb begin
      prod    = PW'(dividend) * PW'(sel ? RECIP1 : RECIP0);
      done_in = start;
      quo_in  = quo_ff;
      if (start) begin
         quo_in = sel ? DW'(prod >> S1) : DW'(prod >> S0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/core/bitmap_allocator_dirty_tracker.sv
// First-fit allocator for block and inode numbers with a dirty bit for each
// metadata block. Both used-bitmaps live in single-port-read memories of
// 32-bit words; after reset a clearing pass writes zeros to every word, one
// word a cycle, and no item is taken until it ends. An allocation reads one
// word a cycle up to the search limit. The metadata index of a number comes
// from a reciprocal multiplication. A free or query of a number past its map
// skips the map lookup. Flush scans one metadata index per cycle while the
// output register is free, up to the smaller of meta_in_use and META_BLOCKS,
// and sends each dirty index as its own item, the last one flagged; with
// nothing dirty it sends a single item with status 2. A result sits in an
// output register, so the block takes its next item while that result waits;
// the next result then waits, and stalls the block, until the output register
// is free.
module bitmap_allocator_dirty_tracker #(
   parameter int BLOCK_COUNT        = bmdt_pkg::BLOCK_COUNT_DEF,
   parameter int INODE_COUNT        = bmdt_pkg::INODE_COUNT_DEF,
   parameter int BITS_PER_MAP_BLOCK = bmdt_pkg::BITS_PER_MAP_DEF,
   parameter int INODES_PER_META    = bmdt_pkg::INODES_PER_META_DEF,
   parameter int META_BLOCKS        = bmdt_pkg::META_BLOCKS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   bmdt_req_if.sink                           req_if,
   bmdt_rsp_if.source                         rsp_if,
   input  logic                               csr_we,
   input  logic [bmdt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bmdt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bmdt_pkg::*;

   localparam int WB      = MAP_WORD_SHIFT;
   localparam int BROWS   = (BLOCK_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int IROWS   = (INODE_COUNT + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int MAXROWS = (BROWS > IROWS) ? BROWS : IROWS;
   localparam int BAW     = (BROWS > 1) ? $clog2(BROWS) : 1;
   localparam int IAW     = (IROWS > 1) ? $clog2(IROWS) : 1;
   localparam int RW      = $clog2(MAXROWS + 1);
   localparam int MAXCNT  = (BLOCK_COUNT > INODE_COUNT) ? BLOCK_COUNT : INODE_COUNT;
   localparam int LW0     = $clog2(MAXCNT + 1);
   localparam int LW      = (LW0 > BLOCKS_REG_W) ? LW0 : BLOCKS_REG_W;
   localparam int DW      = LW;
   localparam int CW      = (((RW + WB) > LW) ? (RW + WB) : LW) + 1;
   localparam int MIW     = $clog2(META_BLOCKS);
   localparam int SW      = DW + 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LOOK,
      S_DIV,
      S_RESP,
      S_FLUSH
   } state_type;

   // Configuration registers.
   logic [BLOCKS_REG_W-1:0] blocks_in_use_ff;
   logic [INODES_REG_W-1:0] inodes_in_use_ff;
   logic [META_REG_W-1:0]   meta_in_use_ff;
   logic [START_REG_W-1:0]  block_map_start_ff;
   logic [START_REG_W-1:0]  inode_map_start_ff;
   logic [START_REG_W-1:0]  inode_table_start_ff;

   state_type               state_ff, state_in;
   logic [RW-1:0]           clr_row_ff, clr_row_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [NUMBER_W-1:0]     num_ff, num_in;
   logic                    sel_ino_ff, sel_ino_in;
   logic [RW-1:0]           issue_row_ff, issue_row_in;
   logic                    chk_vld_ff, chk_vld_in;
   logic [RW-1:0]           chk_row_ff, chk_row_in;
   logic [VALUE_W-1:0]      res_value_ff, res_value_in;
   logic                    res_free_ff, res_free_in;
   status_type              res_status_ff, res_status_in;
   logic [START_REG_W-1:0]  dirty_base_ff, dirty_base_in;
   logic [META_IDX_W-1:0]   flush_idx_ff, flush_idx_in;
   logic [FLUSH_CNT_W-1:0]  flush_cnt_ff, flush_cnt_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [MIW-1:0]          pend_idx_ff, pend_idx_in;
   logic [META_BLOCKS-1:0]  dirty_ff, dirty_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                    rsp_free_ff, rsp_free_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Memory and divider hookup.
   logic                    blk_we, ino_we;
   logic [RW-1:0]           wr_row, rd_row;
   logic [MAP_WORD_W-1:0]   wr_word;
   logic [MAP_WORD_W-1:0]   blk_rd, ino_rd;
   logic                    div_start, div_done;
   logic [DW-1:0]           div_dividend, div_quo;
   logic                    div_sel;

   // Combinational helpers.
   logic [LW-1:0]           lim_blk, lim_ino, lim_sel;
   logic [META_IDX_W-1:0]   meta_lim;
   logic [MAP_WORD_W-1:0]   word_sel;
   logic [MAP_WORD_W-1:0]   avail;
   logic [CW-1:0]           chk_base, room;
   logic [WB-1:0]           hit_pos;
   logic                    hit;
   logic [DW-1:0]           got;
   logic                    issue_ok;
   logic                    slot_free;
   logic [SW-1:0]           dsum;
   logic [MAP_WORD_W-1:0]   num_bit;
   cmd_type                 req_cmd;
   logic                    req_in_blk, req_in_ino;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff     <= BLOCKS_IN_USE_RST;
         inodes_in_use_ff     <= INODES_IN_USE_RST;
         meta_in_use_ff       <= META_IN_USE_RST;
         block_map_start_ff   <= BLOCK_MAP_START_RST;
         inode_map_start_ff   <= INODE_MAP_START_RST;
         inode_table_start_ff <= INODE_TABLE_START_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_BLOCKS_IN_USE:     blocks_in_use_ff     <= csr_wdata;
            REG_INODES_IN_USE:     inodes_in_use_ff     <= csr_wdata[INODES_REG_W-1:0];
            REG_META_IN_USE:       meta_in_use_ff       <= csr_wdata[META_REG_W-1:0];
            REG_BLOCK_MAP_START:   block_map_start_ff   <= csr_wdata[START_REG_W-1:0];
            REG_INODE_MAP_START:   inode_map_start_ff   <= csr_wdata[START_REG_W-1:0];
            REG_INODE_TABLE_START: inode_table_start_ff <= csr_wdata[START_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // Search limits are the smaller of the register and the map size.
   always_comb begin
      lim_blk = (LW'(blocks_in_use_ff) < LW'(BLOCK_COUNT)) ?
                LW'(blocks_in_use_ff) : LW'(BLOCK_COUNT);
      lim_ino = (LW'(inodes_in_use_ff) < LW'(INODE_COUNT)) ?
                LW'(inodes_in_use_ff) : LW'(INODE_COUNT);
      lim_sel = sel_ino_ff ? lim_ino : lim_blk;
      meta_lim = (META_IDX_W'(meta_in_use_ff) < META_IDX_W'(META_BLOCKS)) ?
                 META_IDX_W'(meta_in_use_ff) : META_IDX_W'(META_BLOCKS);
   end

   // Lowest free bit of the word just read, inside the search limit.
   always_comb begin
      word_sel = sel_ino_ff ? ino_rd : blk_rd;
      chk_base = CW'(chk_row_ff) << WB;
      room     = CW'(lim_sel) - chk_base;
      for (int b = 0; b < MAP_WORD_W; b++) begin
         avail[b] = ~word_sel[b] & (room > CW'(b));
      end
      hit     = chk_vld_ff & (|avail);
      hit_pos = '0;
      for (int b = MAP_WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_pos = WB'(b);
         end
      end
      got      = DW'(chk_base | CW'(hit_pos));
      issue_ok = (CW'(issue_row_ff) << WB) < CW'(lim_sel);
      num_bit  = MAP_WORD_W'(1) << num_ff[WB-1:0];
      dsum     = SW'(dirty_base_ff) + SW'(div_quo);
   end

   assign req_cmd    = cmd_type'(req_if.cmd);
   assign req_in_blk = LW'(req_if.number) < LW'(BLOCK_COUNT);
   assign req_in_ino = LW'(req_if.number) < LW'(INODE_COUNT);
   assign slot_free  = ~rsp_vld_ff | rsp_if.ready;

   always_comb begin
      state_in      = state_ff;
      clr_row_in    = clr_row_ff;
      cmd_in        = cmd_ff;
      num_in        = num_ff;
      sel_ino_in    = sel_ino_ff;
      issue_row_in  = issue_row_ff;
      chk_vld_in    = chk_vld_ff;
      chk_row_in    = chk_row_ff;
      res_value_in  = res_value_ff;
      res_free_in   = res_free_ff;
      res_status_in = res_status_ff;
      dirty_base_in = dirty_base_ff;
      flush_idx_in  = flush_idx_ff;
      flush_cnt_in  = flush_cnt_ff;
      pend_vld_in   = pend_vld_ff;
      pend_idx_in   = pend_idx_ff;
      dirty_in      = dirty_ff;
      rsp_vld_in    = rsp_vld_ff & ~rsp_if.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      blk_we       = 1'b0;
      ino_we       = 1'b0;
      wr_row       = '0;
      wr_word      = '0;
      rd_row       = issue_row_ff;
      div_start    = 1'b0;
      div_dividend = DW'(num_ff);
      div_sel      = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_row = clr_row_ff;
            blk_we = (clr_row_ff < RW'(BROWS));
            ino_we = (clr_row_ff < RW'(IROWS));
            if (clr_row_ff == RW'(MAXROWS - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_row_in = clr_row_ff + 1'b1;
            end
         end

         S_IDLE: begin
            rd_row = RW'(req_if.number >> WB);
            if (req_if.valid) begin
               cmd_in        = req_cmd;
               num_in        = req_if.number;
               res_value_in  = '0;
               res_free_in   = 1'b0;
               res_status_in = ST_OK;
               case (req_cmd)
                  CMD_ALLOC_BLK, CMD_ALLOC_INO: begin
                     sel_ino_in    = (req_cmd == CMD_ALLOC_INO);
                     dirty_base_in = (req_cmd == CMD_ALLOC_INO) ?
                                     inode_map_start_ff : block_map_start_ff;
                     issue_row_in  = '0;
                     chk_vld_in    = 1'b0;
                     state_in      = S_SCAN;
                  end
                  CMD_FREE_BLK, CMD_QUERY_BLK: begin
                     sel_ino_in    = 1'b0;
                     dirty_base_in = block_map_start_ff;
                     state_in      = req_in_blk ? S_LOOK : S_RESP;
                  end
                  CMD_FREE_INO, CMD_QUERY_INO: begin
                     sel_ino_in    = 1'b1;
                     dirty_base_in = inode_map_start_ff;
                     state_in      = req_in_ino ? S_LOOK : S_RESP;
                  end
                  CMD_MARK_INO: begin
                     dirty_base_in = inode_table_start_ff;
                     div_start     = 1'b1;
                     div_dividend  = DW'(req_if.number);
                     div_sel       = 1'b1;
                     state_in      = S_DIV;
                  end
                  CMD_FLUSH: begin
                     flush_idx_in = '0;
                     flush_cnt_in = '0;
                     pend_vld_in  = 1'b0;
                     state_in     = S_FLUSH;
                  end
                  default: ;
               endcase
            end
         end

         // One word read per cycle; the word read last cycle is checked now.
         S_SCAN: begin
            if (hit) begin
               wr_row       = chk_row_ff;
               wr_word      = word_sel | (MAP_WORD_W'(1) << hit_pos);
               blk_we       = ~sel_ino_ff;
               ino_we       = sel_ino_ff;
               res_value_in = VALUE_W'(got);
               div_start    = 1'b1;
               div_dividend = got;
               state_in     = S_DIV;
            end else if (issue_ok) begin
               rd_row       = issue_row_ff;
               issue_row_in = issue_row_ff + 1'b1;
               chk_row_in   = issue_row_ff;
               chk_vld_in   = 1'b1;
            end else begin
               res_status_in = ST_NO_SPACE;
               state_in      = S_RESP;
            end
         end

         S_LOOK: begin
            if (cmd_ff == CMD_QUERY_BLK || cmd_ff == CMD_QUERY_INO) begin
               res_free_in = ~word_sel[num_ff[WB-1:0]];
               state_in    = S_RESP;
            end else begin
               wr_row    = RW'(num_ff >> WB);
               wr_word   = word_sel & ~num_bit;
               blk_we    = ~sel_ino_ff;
               ino_we    = sel_ino_ff;
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end

         S_DIV: begin
            if (div_done) begin
               // Indices beyond the metadata area are dropped.
               if (dsum < SW'(META_BLOCKS)) begin
                  dirty_in[dsum[MIW-1:0]] = 1'b1;
               end
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (slot_free) begin
               rsp_vld_in    = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_free_in   = res_free_ff;
               rsp_status_in = res_status_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end

         // A found index is held back one step so that the last one can be
         // flagged once the scan knows no further index follows.
         S_FLUSH: begin
            if (slot_free) begin
               if (flush_idx_ff < meta_lim && flush_cnt_ff < FLUSH_CNT_W'(FLUSH_MAX)) begin
                  if (dirty_ff[flush_idx_ff[MIW-1:0]]) begin
                     dirty_in[flush_idx_ff[MIW-1:0]] = 1'b0;
                     if (pend_vld_ff) begin
                        rsp_vld_in    = 1'b1;
                        rsp_value_in  = VALUE_W'(pend_idx_ff);
                        rsp_free_in   = 1'b0;
                        rsp_status_in = ST_OK;
                        rsp_last_in   = 1'b0;
                     end
                     pend_vld_in  = 1'b1;
                     pend_idx_in  = flush_idx_ff[MIW-1:0];
                     flush_cnt_in = flush_cnt_ff + 1'b1;
                  end
                  flush_idx_in = flush_idx_ff + 1'b1;
               end else begin
                  rsp_vld_in    = 1'b1;
                  rsp_value_in  = pend_vld_ff ? VALUE_W'(pend_idx_ff) : '0;
                  rsp_free_in   = 1'b0;
                  rsp_status_in = pend_vld_ff ? ST_OK : ST_CLEAN;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_row_ff  <= '0;
         chk_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         dirty_ff    <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_row_ff  <= clr_row_in;
         chk_vld_ff  <= chk_vld_in;
         pend_vld_ff <= pend_vld_in;
         dirty_ff    <= dirty_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      cmd_ff        <= cmd_in;
      num_ff        <= num_in;
      sel_ino_ff    <= sel_ino_in;
      issue_row_ff  <= issue_row_in;
      chk_row_ff    <= chk_row_in;
      res_value_ff  <= res_value_in;
      res_free_ff   <= res_free_in;
      res_status_ff <= res_status_in;
      dirty_base_ff <= dirty_base_in;
      flush_idx_ff  <= flush_idx_in;
      flush_cnt_ff  <= flush_cnt_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   bmdt_ram #(
      .WIDTH (MAP_WORD_W),
      .DEPTH (BROWS)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_we),
      .wr_addr (wr_row[BAW-1:0]),
      .wr_data (wr_word),
      .rd_addr (rd_row[BAW-1:0]),
      .rd_data (blk_rd)
   );

   bmdt_ram #(
      .WIDTH (MAP_WORD_W),
      .DEPTH (IROWS)
   ) u_ino_ram (
      .clock   (clock),
      .wr_en   (ino_we),
      .wr_addr (wr_row[IAW-1:0]),
      .wr_data (wr_word),
      .rd_addr (rd_row[IAW-1:0]),
      .rd_data (ino_rd)
   );

   bmdt_div #(
      .DW (DW),
      .D0 (BITS_PER_MAP_BLOCK),
      .D1 (INODES_PER_META)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sel      (div_sel),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_if.ready   = (state_ff == S_IDLE);
   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.value   = rsp_value_ff;
   assign rsp_if.is_free = rsp_free_ff;
   assign rsp_if.status  = rsp_status_ff;
   assign rsp_if.last    = rsp_last_ff;

   // The divider only finishes while the controller waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   // Bitmap words are only written by the clearing pass or a read-modify-write.
   a_ram_write_state: assert property (@(posedge clock) disable iff (reset)
      (blk_we || ino_we) |->
         (state_ff == S_CLEAR || state_ff == S_SCAN || state_ff == S_LOOK))
      else $error("bitmap write outside clear, scan or update");

   // Only a flush in progress leaves an item without the last flag.
   a_nonlast_in_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_last_ff) |-> state_ff == S_FLUSH)
      else $error("item without last flag outside a flush");

   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FLUSH |-> flush_cnt_ff <= FLUSH_CNT_W'(FLUSH_MAX))
      else $error("flush reported more indices than allowed");

endmodule
